[src/prbd_pkg.sv]
// Shared types and constants of the pulse beat and rate detector.
// Used by the register bank, controller, datapath and top level; no dependencies.
package prbd_pkg;

    localparam int SAMPLE_BITS = 18;
    localparam int BASE_BITS   = SAMPLE_BITS + 8;
    localparam int TIME_BITS   = 32;
    localparam int RATE_BITS   = 16;
    localparam int IVAL_BITS   = 16;
    localparam int WGT_BITS    = 16;

    localparam int S_TDATA_BITS = 56;
    localparam int M_TDATA_BITS = 24;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [2:0] REG_PRESENCE_THR = 3'd0;
    localparam logic [2:0] REG_BEAT_DEPTH   = 3'd1;
    localparam logic [2:0] REG_MIN_IVAL     = 3'd2;
    localparam logic [2:0] REG_MAX_IVAL     = 3'd3;
    localparam logic [2:0] REG_BASE_WEIGHT  = 3'd4;

    localparam logic [SAMPLE_BITS-1:0] PRESENCE_THR_RST = SAMPLE_BITS'(50000);
    localparam logic [SAMPLE_BITS-1:0] BEAT_DEPTH_RST   = SAMPLE_BITS'(150);
    localparam logic [IVAL_BITS-1:0]   MIN_IVAL_RST     = 16'd300;
    localparam logic [IVAL_BITS-1:0]   MAX_IVAL_RST     = 16'd2000;
    localparam logic [WGT_BITS-1:0]    BASE_WEIGHT_RST  = 16'd62259;

    // 60000 BPM-ms in Q8.8, dividend of the interval division.
    localparam int DIV_BITS = 24;
    localparam logic [DIV_BITS-1:0] RATE_NUM = 24'd15360000;
    localparam int DIV_STEPS    = DIV_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Division by five as a multiply by ceil(2^22 / 5); exact below 2^19.
    localparam int SMOOTH_BITS  = 19;
    localparam int RECIP_BITS   = 20;
    localparam logic [RECIP_BITS-1:0] RECIP_FIVE = 20'd838861;
    localparam int RECIP_SHIFT  = 22;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] presence_thr;
        logic [SAMPLE_BITS-1:0] beat_depth;
        logic [IVAL_BITS-1:0]   min_ival;
        logic [IVAL_BITS-1:0]   max_ival;
        logic [WGT_BITS-1:0]    base_weight;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic eval;
        logic beat;
        logic dinit;
        logic dstep;
        logic sadd;
        logic smul;
        logic sfin;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic present;
        logic go_div;
    } dp_stat_t;

endpackage

[src/prbd_cfg.sv]
// Configuration register bank behind the APB-style port.
// Depends on prbd_pkg for register indexes, reset values and cfg_t.
module prbd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prbd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [prbd_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [prbd_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output prbd_pkg::cfg_t                     cfg
);
    import prbd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.presence_thr <= PRESENCE_THR_RST;
            cfg_reg.beat_depth   <= BEAT_DEPTH_RST;
            cfg_reg.min_ival     <= MIN_IVAL_RST;
            cfg_reg.max_ival     <= MAX_IVAL_RST;
            cfg_reg.base_weight  <= BASE_WEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PRESENCE_THR: cfg_reg.presence_thr <= pwdata[SAMPLE_BITS-1:0];
                REG_BEAT_DEPTH:   cfg_reg.beat_depth   <= pwdata[SAMPLE_BITS-1:0];
                REG_MIN_IVAL:     cfg_reg.min_ival     <= pwdata[IVAL_BITS-1:0];
                REG_MAX_IVAL:     cfg_reg.max_ival     <= pwdata[IVAL_BITS-1:0];
                REG_BASE_WEIGHT:  cfg_reg.base_weight  <= pwdata[WGT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PRESENCE_THR: prdata = CFG_DATA_BITS'(cfg_reg.presence_thr);
            REG_BEAT_DEPTH:   prdata = CFG_DATA_BITS'(cfg_reg.beat_depth);
            REG_MIN_IVAL:     prdata = CFG_DATA_BITS'(cfg_reg.min_ival);
            REG_MAX_IVAL:     prdata = CFG_DATA_BITS'(cfg_reg.max_ival);
            REG_BASE_WEIGHT:  prdata = CFG_DATA_BITS'(cfg_reg.base_weight);
            default:          prdata = '0;
        endcase
    end

endmodule

[src/prbd_dp.sv]
// Datapath: baseline tracker, beat detector, shared-step interval divider,
// rate smoother and output register. Depends on prbd_pkg.
module prbd_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  prbd_pkg::cfg_t                    cfg,
    input  prbd_pkg::dp_cmd_t                 cmd,
    input  logic [prbd_pkg::S_TDATA_BITS-1:0] in_data,
    output prbd_pkg::dp_stat_t                stat,
    output logic [prbd_pkg::M_TDATA_BITS-1:0] out_data
);
    import prbd_pkg::*;

    // Captured item.
    logic [SAMPLE_BITS-1:0] ir_reg;
    logic [TIME_BITS-1:0]   time_reg;

    // Block state.
    logic [BASE_BITS-1:0] baseline_reg;
    logic                 tracking_reg;
    logic                 disarmed_reg;
    logic [TIME_BITS-1:0] last_beat_reg;
    logic [RATE_BITS-1:0] rate_reg;

    // Result flags of the current item.
    logic present_reg, removed_reg, beat_reg, upd_reg, go_div_reg;

    // Working registers.
    logic signed [BASE_BITS+17:0] prod_reg;
    logic [IVAL_BITS-1:0]         dt_reg;
    logic [DIV_BITS-1:0]          num_reg;
    logic [IVAL_BITS-1:0]         rem_reg;
    logic [RATE_BITS-1:0]         cur_reg;
    logic                         first_reg;
    logic [SMOOTH_BITS-1:0]       n_reg;
    logic [SMOOTH_BITS+RECIP_BITS-1:0] prod2_reg;
    logic [M_TDATA_BITS-1:0]      out_reg;

    logic [BASE_BITS-1:0]         x;
    logic                         present;
    logic [BASE_BITS-1:0]         base0;
    logic signed [BASE_BITS:0]    diff;
    logic signed [WGT_BITS:0]     wgt;
    logic signed [BASE_BITS+17:0] mul_full;
    logic signed [BASE_BITS+17:0] rsum;
    logic [BASE_BITS+1:0]         base_new;
    logic signed [BASE_BITS+1:0]  residual;
    logic signed [BASE_BITS+1:0]  depth_sum;
    logic [TIME_BITS-1:0]         dt32;
    logic                         in_range;
    logic                         beat_now;
    logic [IVAL_BITS+1:0]         trial;
    logic [RATE_BITS-1:0]         cur_sat;

    assign x        = {ir_reg, 8'b0};
    assign present  = ir_reg > cfg.presence_thr;
    assign base0    = tracking_reg ? baseline_reg : x;
    assign diff     = $signed({1'b0, base0}) - $signed({1'b0, x});
    assign wgt      = $signed({1'b0, cfg.base_weight});
    assign mul_full = diff * wgt;

    // New baseline = x + round((base0 - x) * w / 2^16), floor after the half add.
    assign rsum     = prod_reg + (BASE_BITS+18)'(32768);
    assign base_new = {2'b0, x} + rsum[BASE_BITS+17:16];

    assign residual  = $signed({2'b0, x}) - $signed({2'b0, baseline_reg});
    assign depth_sum = residual + $signed({2'b0, cfg.beat_depth, 8'b0});
    assign beat_now  = depth_sum[BASE_BITS+1] & ~disarmed_reg;
    assign dt32      = time_reg - last_beat_reg;
    assign in_range  = (dt32 > {16'b0, cfg.min_ival}) && (dt32 < {16'b0, cfg.max_ival});

    assign trial   = {1'b0, rem_reg, num_reg[DIV_BITS-1]} - {2'b0, dt_reg};
    assign cur_sat = (|num_reg[DIV_BITS-1:RATE_BITS]) ? '1 : num_reg[RATE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= '0;
            tracking_reg  <= 1'b0;
            disarmed_reg  <= 1'b0;
            last_beat_reg <= '0;
            rate_reg      <= '0;
            present_reg   <= 1'b0;
            removed_reg   <= 1'b0;
            beat_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            go_div_reg    <= 1'b0;
        end else begin
            if (cmd.mul) begin
                present_reg <= present;
                removed_reg <= 1'b0;
                beat_reg    <= 1'b0;
                upd_reg     <= 1'b0;
                go_div_reg  <= 1'b0;
                if (!present && tracking_reg) begin
                    removed_reg  <= 1'b1;
                    tracking_reg <= 1'b0;
                    baseline_reg <= '0;
                    rate_reg     <= '0;
                end
            end
            if (cmd.eval && present_reg) begin
                baseline_reg <= base_new[BASE_BITS-1:0];
                tracking_reg <= 1'b1;
            end
            if (cmd.beat) begin
                if (beat_now) begin
                    beat_reg      <= 1'b1;
                    disarmed_reg  <= 1'b1;
                    last_beat_reg <= time_reg;
                    go_div_reg    <= in_range;
                end else if (!residual[BASE_BITS+1] && residual != '0) begin
                    disarmed_reg <= 1'b0;
                end
            end
            if (cmd.sfin) begin
                rate_reg <= first_reg ? cur_reg
                                      : prod2_reg[RECIP_SHIFT+RATE_BITS-1:RECIP_SHIFT];
                upd_reg  <= 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ir_reg   <= in_data[SAMPLE_BITS-1:0];
            time_reg <= in_data[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
        end
        if (cmd.mul) begin
            prod_reg <= mul_full;
        end
        if (cmd.beat) begin
            dt_reg <= dt32[IVAL_BITS-1:0];
        end
        if (cmd.dinit) begin
            num_reg <= RATE_NUM + DIV_BITS'(dt_reg[IVAL_BITS-1:1]);
            rem_reg <= '0;
        end
        if (cmd.dstep) begin
            if (!trial[IVAL_BITS+1]) begin
                rem_reg <= trial[IVAL_BITS-1:0];
                num_reg <= {num_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[IVAL_BITS-2:0], num_reg[DIV_BITS-1]};
                num_reg <= {num_reg[DIV_BITS-2:0], 1'b0};
            end
        end
        if (cmd.sadd) begin
            cur_reg   <= cur_sat;
            first_reg <= (rate_reg == '0);
            n_reg     <= {1'b0, rate_reg, 2'b0} + SMOOTH_BITS'(cur_sat) + SMOOTH_BITS'(2);
        end
        if (cmd.smul) begin
            prod2_reg <= (SMOOTH_BITS+RECIP_BITS)'(n_reg) * (SMOOTH_BITS+RECIP_BITS)'(RECIP_FIVE);
        end
        if (cmd.out_load) begin
            out_reg <= {4'b0, rate_reg, upd_reg, beat_reg, removed_reg, present_reg};
        end
    end

    assign stat.present = present_reg;
    assign stat.go_div  = go_div_reg;
    assign out_data     = out_reg;

    a_upd_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_reg |-> beat_reg)
        else $error("rate update flagged without a beat");
    a_removed_not_present: assert property (@(posedge aclk) disable iff (!aresetn)
        removed_reg |-> (!present_reg && !tracking_reg))
        else $error("removal flagged while a finger is present or tracked");

endmodule

[src/prbd_ctrl.sv]
// Sequencing state machine: steps the datapath through one item and runs
// the stream handshakes. Depends on prbd_pkg for command and status types.
module prbd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  prbd_pkg::dp_stat_t  stat,
    output prbd_pkg::dp_cmd_t   cmd
);
    import prbd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_EVAL, S_BEAT, S_DINIT, S_DIV, S_SADD, S_SMUL, S_SFIN, S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = stat.present ? S_BEAT : S_DONE;
            end
            S_BEAT: begin
                cmd.beat   = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.dinit  = 1'b1;
                cnt_next   = '0;
                state_next = stat.go_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                cmd.dstep = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    state_next = S_SADD;
                end
            end
            S_SADD: begin
                cmd.sadd   = 1'b1;
                state_next = S_SMUL;
            end
            S_SMUL: begin
                cmd.smul   = 1'b1;
                state_next = S_SFIN;
            end
            S_SFIN: begin
                cmd.sfin   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded over an untaken result");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg < DIV_CNT_BITS'(DIV_STEPS)))
        else $error("divider step count out of range");

endmodule

[src/pulse_beat_rate_detector.sv]
// Top level of the pulse beat and rate detector.
// Instantiates prbd_cfg, prbd_ctrl and prbd_dp; depends on prbd_pkg.
//
// Usage:
// Each input item carries one infrared sample and its millisecond timestamp
// on the s_ channel; each item gives exactly one result item on the m_
// channel with presence, removal, beat and rate-update flags and the
// smoothed rate in Q8.8 beats per minute. Thresholds, interval limits and
// the baseline weight are set through the APB-style port at byte addresses
// 0, 4, 8, 12 and 16, and should only be written while the block is idle.
// The block works on one item at a time. An absent-finger item passes through
// the multiply and evaluate steps, a present item without an accepted beat
// interval also through the beat and divider set-up steps, and an item that
// updates the rate also through the 24 one-bit steps of the interval divider
// and the smoothing steps. The next item can be accepted once the result is
// placed in the output register. If the receiver stalls, the result waits in
// the output register and the next item is still accepted and processed; the
// controller then waits in its done state until the output register is free.
// Reset (aresetn low, synchronous) clears the baseline, the tracking and
// arming state, the last beat time and the rate, empties the output and
// returns the registers to their default values.
module pulse_beat_rate_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: ir_sample [17:0], time_ms [49:18], zero fill [55:50]
    input  logic [prbd_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: finger_present [0], finger_removed [1], beat_detected [2],
    // rate_updated [3], rate_bpm [19:4], zero fill [23:20]
    output logic [prbd_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prbd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [prbd_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [prbd_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import prbd_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register bank.
    prbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns both handshakes and the step sequence.
    prbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the block state and the result register.
    prbd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule

[tb/beat_rate_tracker_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class for the pulse beat and rate detector testbench: a predictor of
// the baseline, beat and rate behaviour and a queue of expected result items.
// Depends on prbd_pkg for widths, register indexes and reset values.
package beat_rate_tracker_pkg;

    import prbd_pkg::*;

    typedef struct packed {
        logic [RATE_BITS-1:0] rate;
        logic                 updated;
        logic                 beat;
        logic                 removed;
        logic                 present;
    } rate_result_t;

    class beat_rate_tracker;
        logic [SAMPLE_BITS-1:0] presence_thr;
        logic [SAMPLE_BITS-1:0] beat_depth;
        logic [IVAL_BITS-1:0]   min_ival;
        logic [IVAL_BITS-1:0]   max_ival;
        logic [WGT_BITS-1:0]    base_weight;

        logic [BASE_BITS-1:0]   baseline;
        bit                     tracking;
        bit                     disarmed;
        logic [TIME_BITS-1:0]   last_beat_ms;
        logic [RATE_BITS-1:0]   rate;

        rate_result_t expected_results[$];
        int           mismatches;
        int           results_seen;

        function new();
            presence_thr = PRESENCE_THR_RST;
            beat_depth   = BEAT_DEPTH_RST;
            min_ival     = MIN_IVAL_RST;
            max_ival     = MAX_IVAL_RST;
            base_weight  = BASE_WEIGHT_RST;
            baseline     = '0;
            tracking     = 1'b0;
            disarmed     = 1'b0;
            last_beat_ms = '0;
            rate         = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_PRESENCE_THR: presence_thr = value[SAMPLE_BITS-1:0];
                REG_BEAT_DEPTH:   beat_depth   = value[SAMPLE_BITS-1:0];
                REG_MIN_IVAL:     min_ival     = value[IVAL_BITS-1:0];
                REG_MAX_IVAL:     max_ival     = value[IVAL_BITS-1:0];
                REG_BASE_WEIGHT:  base_weight  = value[WGT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Works out the result of one accepted sample and queues it.
        function void note_sample(logic [SAMPLE_BITS-1:0] ir, logic [TIME_BITS-1:0] now);
            rate_result_t         r;
            logic [63:0]          x;
            logic [63:0]          w;
            logic [63:0]          mixed;
            logic [63:0]          cur;
            longint               residual;
            longint               limit;
            logic [TIME_BITS-1:0] dt;
            r = '0;
            if (ir > presence_thr) begin
                r.present = 1'b1;
                x = 64'(ir) << 8;
                w = 64'(base_weight);
                if (!tracking) begin
                    baseline = x[BASE_BITS-1:0];
                    tracking = 1'b1;
                end
                mixed    = (64'(baseline) * w + x * (64'd65536 - w) + 64'd32768) >> 16;
                baseline = mixed[BASE_BITS-1:0];
                residual = longint'(x) - longint'(64'(baseline));
                limit    = -longint'(64'(beat_depth) << 8);
                if (residual < limit && !disarmed) begin
                    dt           = now - last_beat_ms;
                    r.beat       = 1'b1;
                    disarmed     = 1'b1;
                    last_beat_ms = now;
                    if (dt > 32'(min_ival) && dt < 32'(max_ival)) begin
                        cur = (64'd15360000 + 64'(dt / 2)) / 64'(dt);
                        if (cur > 64'd65535)
                            cur = 64'd65535;
                        if (rate == '0)
                            rate = cur[RATE_BITS-1:0];
                        else
                            rate = RATE_BITS'((64'd4 * 64'(rate) + cur + 64'd2) / 64'd5);
                        r.updated = 1'b1;
                    end
                end else if (residual > 0) begin
                    disarmed = 1'b0;
                end
            end else if (tracking) begin
                r.removed = 1'b1;
                tracking  = 1'b0;
                baseline  = '0;
                rate      = '0;
            end
            r.rate = rate;
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what);
            $display("result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_BITS-1:0] data);
            rate_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result item %h", data));
                return;
            end
            want = expected_results.pop_front();
            if (data[0] !== want.present)
                report_mismatch($sformatf("finger_present %b, want %b", data[0], want.present));
            if (data[1] !== want.removed)
                report_mismatch($sformatf("finger_removed %b, want %b", data[1], want.removed));
            if (data[2] !== want.beat)
                report_mismatch($sformatf("beat_detected %b, want %b", data[2], want.beat));
            if (data[3] !== want.updated)
                report_mismatch($sformatf("rate_updated %b, want %b", data[3], want.updated));
            if (data[19:4] !== want.rate)
                report_mismatch($sformatf("rate_bpm %h, want %h", data[19:4], want.rate));
            if (data[M_TDATA_BITS-1:20] !== '0)
                report_mismatch($sformatf("fill bits %h not zero", data[M_TDATA_BITS-1:20]));
        endtask
    endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top level of the testbench for pulse_beat_rate_detector: clock, reset, stream and
// APB drivers, and the stimulus phases. Depends on prbd_pkg and beat_rate_tracker_pkg.
module testbench;

    import prbd_pkg::*;
    import beat_rate_tracker_pkg::*;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic [S_TDATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [CFG_DATA_BITS-1:0] pwdata   = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // When set, neither side of the stream idles: a stretch at full rate.
    bit                   no_idle    = 1'b0;
    int                   stall_left = 0;
    // Running millisecond clock used for the timestamps of well-formed pulse trains.
    logic [TIME_BITS-1:0] ms_clock   = '0;

    beat_rate_tracker tracker = new();

    pulse_beat_rate_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Idle lengths: mostly none or short, now and then a long one that may outlast the
    // slowest item of the block.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(int v);
        if (v < 0)
            return '0;
        if (v > 262143)
            return '1;
        return SAMPLE_BITS'(v);
    endfunction

    // Now and then sets random bits above the register's width, which the block must ignore.
    function automatic logic [31:0] with_junk(logic [31:0] v, int width);
        logic [31:0] keep;
        keep = (32'h1 << width) - 32'h1;
        if ($urandom_range(0, 1) == 1)
            return (v & keep) | ($urandom & ~keep);
        return v & keep;
    endfunction

    // Offers one sample item, entered and left at a falling edge. tvalid stays high
    // on return so that back-to-back items need no second assignment in one step.
    task automatic drive_sample(input logic [SAMPLE_BITS-1:0] ir, input logic [TIME_BITS-1:0] t);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= S_TDATA_BITS'({t, ir});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_sample(ir, t);
        @(negedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Holds the sender back until every expected result has come, then lets the
    // block's longest latency pass so that it is certainly idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register settings per phase. The first few are fixed, with the extremes of
    // every register among them; the rest are drawn at random.
    task automatic configure(input int phase);
        logic [31:0] thr, depth, lo, hi, wgt;
        case (phase)
            0: begin
                thr = 50000; depth = 150; lo = 300; hi = 2000; wgt = 62259;
            end
            1: begin
                thr = 0; depth = 0; lo = 0; hi = 65535; wgt = 65535;
            end
            2: begin
                thr = 262143; depth = 262143; lo = 65535; hi = 0; wgt = 0;
            end
            3: begin
                // The limits leave no room for any interval.
                thr = 30000; depth = 300; lo = 1000; hi = 1001; wgt = 60000;
            end
            4: begin
                thr = 40000; depth = 100; lo = 100; hi = 3000; wgt = 0;
            end
            default: begin
                thr   = $urandom_range(0, 120000);
                depth = $urandom_range(0, 3000);
                lo    = $urandom_range(0, 600);
                hi    = $urandom_range(lo + 2, 4000);
                wgt   = $urandom_range(45000, 65535);
            end
        endcase
        write_register(REG_PRESENCE_THR, with_junk(thr, SAMPLE_BITS));
        write_register(REG_BEAT_DEPTH, with_junk(depth, SAMPLE_BITS));
        write_register(REG_MIN_IVAL, with_junk(lo, IVAL_BITS));
        write_register(REG_MAX_IVAL, with_junk(hi, IVAL_BITS));
        write_register(REG_BASE_WEIGHT, with_junk(wgt, WGT_BITS));
    endtask

    // Random stimulus. Most of it is square-wave pulse trains above the presence
    // threshold, which drive the baseline, arming and interval logic; the rest is
    // raw noise with random timestamps and short runs with the finger absent.
    task automatic run_phase(input int n_items);
        int done, kind, level, amp, period, cycles, step, k, n, ir, thr;
        done = 0;
        thr  = int'(tracker.presence_thr);
        while (done < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                amp    = $urandom_range(300, 30000);
                period = $urandom_range(4, 16);
                cycles = $urandom_range(2, 5);
                // Short steps give intervals short enough to saturate the rate.
                step   = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 40)
                                                    : $urandom_range(30, 250);
                level  = int'($urandom_range(thr + amp + 500, 240000));
                if ($urandom_range(0, 19) == 0)
                    ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                for (k = 0; k < period * cycles && done < n_items; k++) begin
                    ir = level + (((k % period) < period / 2) ? amp : -amp)
                         + int'($urandom_range(0, amp / 4)) - amp / 8;
                    ms_clock = ms_clock + step;
                    drive_sample(clamp_sample(ir), ms_clock);
                    done++;
                end
            end else if (kind < 85) begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n && done < n_items; k++) begin
                    drive_sample(SAMPLE_BITS'($urandom), $urandom);
                    done++;
                end
                if ($urandom_range(0, 3) == 0)
                    ms_clock = $urandom;
            end else begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n && done < n_items; k++) begin
                    ms_clock = ms_clock + $urandom_range(1, 500);
                    drive_sample(SAMPLE_BITS'($urandom_range(0, thr)), ms_clock);
                    done++;
                end
            end
        end
    endtask

    // Receiver: ready changes at the falling edge, with random stalls.
    initial begin
        forever begin
            @(negedge aclk);
            if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    initial begin
        int phase;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed items under the reset settings. An absent sample while idle, the
        // extremes of both fields, a sample equal to the threshold, which counts as
        // absent and ends tracking, then a second absent sample with no new event.
        drive_sample(18'd0, 32'd0);
        drive_sample(18'h3FFFF, 32'hFFFF_FFFF);
        drive_sample(18'd50000, 32'd10);
        drive_sample(18'd50000, 32'd20);
        // A fresh seed, a rise that arms, and a drop that beats with an interval
        // from the last beat time that is too short to be taken.
        drive_sample(18'd100000, 32'd30);
        drive_sample(18'd104000, 32'd40);
        drive_sample(18'd90000, 32'd100);
        // Still low while disarmed: no second beat.
        drive_sample(18'd88000, 32'd150);
        // Re-arm, then a valid interval that sets the first rate directly.
        drive_sample(18'd110000, 32'd200);
        drive_sample(18'd90000, 32'd600);
        // A second valid interval, smoothed into the held rate.
        drive_sample(18'd110000, 32'd650);
        drive_sample(18'd90000, 32'd1300);
        // An interval below the lower limit: a beat without a rate update.
        drive_sample(18'd110000, 32'd1350);
        drive_sample(18'd90000, 32'd1400);
        // An interval equal to the upper limit, which is rejected as well.
        drive_sample(18'd110000, 32'd2000);
        drive_sample(18'd90000, 32'd3400);
        // Just above the lower limit.
        drive_sample(18'd110000, 32'd3500);
        drive_sample(18'd90000, 32'd3701);
        // A beat just before the timestamp wraps, and one after it.
        drive_sample(18'd110000, 32'hFFFF_FD00);
        drive_sample(18'd90000, 32'hFFFF_FE00);
        drive_sample(18'd110000, 32'hFFFF_FF00);
        drive_sample(18'd90000, 32'h0000_0100);
        // Removal clears the rate; the held rate then reads zero.
        drive_sample(18'd0, 32'h0000_0200);
        drive_sample(18'd49999, 32'h0000_0300);

        for (phase = 0; phase < 10; phase++) begin
            settle();
            configure(phase);
            no_idle = (phase == 1 || phase == 6);
            ms_clock = $urandom;
            run_phase(phase == 2 ? 20 : 55);
        end
        settle();

        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
